[src/lfr_pkg.sv]
// Package for the LED fade ramp controller: command and direction codes,
// state, command and configuration structs. No dependencies.
`default_nettype none

package lfr_pkg;

    typedef enum logic [2:0] {
        KIND_TOGGLE  = 3'd0,
        KIND_OFF     = 3'd1,
        KIND_ON      = 3'd2,
        KIND_SET_MAX = 3'd3,
        KIND_DISABLE = 3'd4,
        KIND_ENABLE  = 3'd5,
        KIND_TICK    = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_DOWN = 2'd1,
        DIR_UP   = 2'd2
    } t_dir;

    // APB register map (byte addresses)
    localparam int unsigned ADDR_W          = 3;
    localparam logic [ADDR_W-1:0] ADDR_STEP   = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_PERIOD = 3'd4;

    localparam logic [7:0]  STEP_RESET     = 8'd5;
    localparam logic [15:0] PERIOD_RESET   = 16'd100;
    localparam logic [7:0]  MAX_BRT_RESET  = 8'd100;
    localparam logic [7:0]  LEVEL_FULL     = 8'd255;

    typedef struct packed {
        logic [7:0]  level;
        t_dir        direction;
        logic        enabled;
        logic [7:0]  max_brightness;
        logic        timer_running;
        logic [15:0] timer_count;
    } t_state;

    typedef struct packed {
        logic [2:0]         kind;
        logic               ramped;
        logic signed [15:0] brightness_value;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  ramp_step;
        logic [15:0] ramp_period;
    } t_cfg;

endpackage

`default_nettype wire

[src/lfr_cmd_if.sv]
// Command channel of the LED fade ramp controller: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface lfr_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic               ramped;
    logic signed [15:0] brightness_value;

    modport source (output valid, kind, ramped, brightness_value, input ready);
    modport sink   (input valid, kind, ramped, brightness_value, output ready);
endinterface

`default_nettype wire

[src/lfr_res_if.sv]
// Result channel of the LED fade ramp controller: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface lfr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] drive_level;
    logic       light_on;
    logic [1:0] fade_direction;
    logic       enabled_flag;

    modport source (output valid, drive_level, light_on, fade_direction, enabled_flag,
                    input ready);
    modport sink   (input valid, drive_level, light_on, fade_direction, enabled_flag,
                    output ready);
endinterface

`default_nettype wire

[src/lfr_step.sv]
// Next-state logic for one command or tick of the LED fade ramp controller.
// Depends on lfr_pkg.
`default_nettype none

module lfr_step (
    input  wire lfr_pkg::t_state i_state,
    input  wire lfr_pkg::t_cmd   i_cmd,
    input  wire lfr_pkg::t_cfg   i_cfg,
    output lfr_pkg::t_state      o_state
);

    logic signed [9:0] ramp_next;
    logic              expire;
    logic [7:0]        new_max;

    // level +/- step, wide enough to see both overflow and underflow
    always_comb begin
        if (i_state.direction == lfr_pkg::DIR_DOWN) begin
            ramp_next = $signed({2'b00, i_state.level}) - $signed({2'b00, i_cfg.ramp_step});
        end else begin
            ramp_next = $signed({2'b00, i_state.level}) + $signed({2'b00, i_cfg.ramp_step});
        end
    end

    assign expire = i_state.timer_running && (i_state.timer_count <= 16'd1);

    always_comb begin
        if (i_cmd.brightness_value < 0) begin
            new_max = 8'd0;
        end else if (i_cmd.brightness_value > 16'sd255) begin
            new_max = lfr_pkg::LEVEL_FULL;
        end else begin
            new_max = i_cmd.brightness_value[7:0];
        end
    end

    always_comb begin
        o_state = i_state;
        case (i_cmd.kind)
            lfr_pkg::KIND_TOGGLE: begin
                if (i_state.enabled) begin
                    if (i_cmd.ramped) begin
                        case (i_state.direction)
                            lfr_pkg::DIR_DOWN: o_state.direction = lfr_pkg::DIR_UP;
                            lfr_pkg::DIR_UP:   o_state.direction = lfr_pkg::DIR_DOWN;
                            default: begin
                                o_state.direction = (i_state.level != 8'd0) ?
                                                    lfr_pkg::DIR_DOWN : lfr_pkg::DIR_UP;
                            end
                        endcase
                        o_state.timer_running = 1'b1;
                        o_state.timer_count   = i_cfg.ramp_period;
                    end else begin
                        o_state.level = (i_state.level != 8'd0) ? 8'd0 : i_state.max_brightness;
                    end
                end
            end
            lfr_pkg::KIND_OFF, lfr_pkg::KIND_DISABLE: begin
                o_state.timer_running = 1'b0;
                o_state.direction     = lfr_pkg::DIR_IDLE;
                o_state.level         = 8'd0;
                if (i_cmd.kind == lfr_pkg::KIND_DISABLE) begin
                    o_state.enabled = 1'b0;
                end
            end
            lfr_pkg::KIND_ON: begin
                if (i_state.enabled && i_state.level == 8'd0) begin
                    o_state.level = i_state.max_brightness;
                end
            end
            lfr_pkg::KIND_SET_MAX: begin
                o_state.max_brightness = new_max;
                if (i_state.level != 8'd0 && i_state.direction == lfr_pkg::DIR_IDLE) begin
                    o_state.level = new_max;
                end
            end
            lfr_pkg::KIND_ENABLE: begin
                o_state.enabled = 1'b1;
            end
            lfr_pkg::KIND_TICK: begin
                if (expire) begin
                    o_state.timer_running = 1'b0;
                    o_state.timer_count   = 16'd0;
                    if (i_state.enabled && i_state.direction != lfr_pkg::DIR_IDLE) begin
                        if (ramp_next > $signed({2'b00, i_state.max_brightness})) begin
                            o_state.level     = i_state.max_brightness;
                            o_state.direction = lfr_pkg::DIR_IDLE;
                        end else if (ramp_next < 0) begin
                            o_state.level     = 8'd0;
                            o_state.direction = lfr_pkg::DIR_IDLE;
                        end else begin
                            o_state.level         = ramp_next[7:0];
                            o_state.timer_running = 1'b1;
                            o_state.timer_count   = i_cfg.ramp_period;
                        end
                    end
                end else if (i_state.timer_running) begin
                    o_state.timer_count = i_state.timer_count - 16'd1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/led_fade_ramp_controller_unit.sv]
// LED fade ramp controller: one command or tick in, one drive-level result out.
// A request is first loaded into the input register and then, once the output
// can take it, into the result register. Throughput: one request per cycle
// while results are taken, set by the single state update in the step logic.
// Synchronous active-low reset: level 0, idle, enabled, max brightness 100,
// timer stopped, step 5, period 100.
// Depends on lfr_pkg, lfr_cmd_if, lfr_res_if, lfr_step.
`default_nettype none

module led_fade_ramp_controller_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    lfr_cmd_if.sink                     i_cmd,
    lfr_res_if.source                   o_res,
    // APB configuration port
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [lfr_pkg::ADDR_W-1:0]   paddr,
    input  wire [31:0]                  pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Decode on paddr[2] only: 0 = step, 4 = period.
    // ------------------------------------------------------------------
    lfr_pkg::t_cfg r_cfg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_step   <= lfr_pkg::STEP_RESET;
            r_cfg.ramp_period <= lfr_pkg::PERIOD_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == lfr_pkg::ADDR_PERIOD[2]) begin
                r_cfg.ramp_period <= pwdata[15:0];
            end else begin
                r_cfg.ramp_step <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == lfr_pkg::ADDR_PERIOD[2]) begin
            prdata = {16'd0, r_cfg.ramp_period};
        end else begin
            prdata = {24'd0, r_cfg.ramp_step};
        end
    end

    // ------------------------------------------------------------------
    // Input register. It refills while a finished result is still waiting
    // at the output; upstream is held once both input and result are full.
    // ------------------------------------------------------------------
    logic          r_in_valid;
    lfr_pkg::t_cmd r_in;
    logic          r_out_valid;
    logic          advance;
    logic          in_take;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign in_take     = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.kind             <= i_cmd.kind;
            r_in.ramped           <= i_cmd.ramped;
            r_in.brightness_value <= i_cmd.brightness_value;
        end
    end

    // ------------------------------------------------------------------
    // Controller state, updated once per request as it leaves the input
    // register. The result is a snapshot of the updated state.
    // ------------------------------------------------------------------
    lfr_pkg::t_state r_state;
    lfr_pkg::t_state n_state;

    lfr_step u_step (
        .i_state (r_state),
        .i_cmd   (r_in),
        .i_cfg   (r_cfg),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.level          <= 8'd0;
            r_state.direction      <= lfr_pkg::DIR_IDLE;
            r_state.enabled        <= 1'b1;
            r_state.max_brightness <= lfr_pkg::MAX_BRT_RESET;
            r_state.timer_running  <= 1'b0;
            r_state.timer_count    <= 16'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [7:0] r_out_level;
    logic [1:0] r_out_dir;
    logic       r_out_enabled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_level   <= n_state.level;
            r_out_dir     <= n_state.direction;
            r_out_enabled <= n_state.enabled;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.drive_level    = r_out_level;
    assign o_res.light_on       = (r_out_level != 8'd0);
    assign o_res.fade_direction = r_out_dir;
    assign o_res.enabled_flag   = r_out_enabled;

endmodule

`default_nettype wire
